>>> design/bcpa_pkg.sv
// ----------------------------------------------------------------------------
// bcpa_pkg: shared types and constants for the page allocator
// Request and result records, status and operation codes, page geometry.
// ----------------------------------------------------------------------------
package bcpa_pkg;

  localparam int MAX_PAGE_FRAMES = 4096;
  localparam int PAGE_SHIFT      = 12;
  localparam int PAGE_BYTES      = 1 << PAGE_SHIFT;
  localparam int NEED_W          = 14;
  localparam int ENTRY_W         = 9;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOMEM    = 3'd1;
  localparam logic [2:0] ST_NOWRITE  = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [3:0] RT_USABLE_A = 4'd7;
  localparam logic [3:0] RT_USABLE_B = 4'd3;
  localparam logic [3:0] RT_USABLE_C = 4'd4;

  localparam logic CFG_KERNEL_FLAGS = 1'b0;
  localparam logic CFG_WRITE_MASK   = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  region_type;
    logic [24:0] size_bytes;
    logic [23:0] address;
    logic [7:0]  request_flags;
    logic [11:0] page_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] first_page;
    logic [23:0] page_address;
    logic [24:0] granted_bytes;
    logic        is_allocated;
    logic [7:0]  page_flags;
  } res_t;

  typedef struct packed {
    logic                wr_en;
    logic [31:0]         addr;
    logic [ENTRY_W-1:0]  wr_data;
  } ram_cmd_t;

endpackage

>>> design/bcpa_page_ram.sv
// ----------------------------------------------------------------------------
// bcpa_page_ram: page entry store
// One entry per page frame: allocated bit over flag byte, registered read.
// ----------------------------------------------------------------------------
module bcpa_page_ram #(
  parameter int DEPTH = bcpa_pkg::MAX_PAGE_FRAMES
) (
  input  logic                          clk,
  input  bcpa_pkg::ram_cmd_t            cmd,
  output logic [bcpa_pkg::ENTRY_W-1:0]  rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bcpa_pkg::ENTRY_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr[AW-1:0]] <= cmd.wr_data;
    end
    rd_data <= mem[cmd.addr[AW-1:0]];
  end

endmodule

>>> design/bitmap_contiguous_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_contiguous_page_allocator_unit: first-fit page frame allocator
// Append, alloc, free and query over a per-page allocated bit and flag byte.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on out_res for exactly one cycle with out_valid high and must be
// captured then, since the result side cannot stall. All page state lives in
// one single-port RAM; each page read passes a read state, then an evaluate
// state. Query reads at most one page; alloc reads pages scanned from the hint,
// writes each page of the run, then searches for a new hint if the run
// began at it; free walks its pages twice (permission check, then release).
// Only pages already appended are read from the store, so no clearing pass
// runs after reset. Configuration writes are always ready; to apply them to
// the next request, the user must write while idle; the block does not check.
module bitmap_contiguous_page_allocator_unit #(
  parameter int MAX_PAGE_FRAMES = bcpa_pkg::MAX_PAGE_FRAMES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  bcpa_pkg::req_t  in_req,
  output logic            out_valid,
  output bcpa_pkg::res_t  out_res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data
);

  localparam int IW = (MAX_PAGE_FRAMES > 1) ? $clog2(MAX_PAGE_FRAMES) : 1;
  localparam int CW = $clog2(MAX_PAGE_FRAMES + 1);
  localparam int NW = bcpa_pkg::NEED_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_A_RD = 10'b0000000010,
    S_A_EV = 10'b0000000100,
    S_MARK = 10'b0000001000,
    S_H_RD = 10'b0000010000,
    S_H_EV = 10'b0000100000,
    S_F_RD = 10'b0001000000,
    S_F_EV = 10'b0010000000,
    S_Q_RD = 10'b0100000000,
    S_Q_EV = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       managed_r, managed_nxt;
  logic [IW-1:0]       hint_r, hint_nxt;
  logic                hint_set_r, hint_set_nxt;
  logic [7:0]          kflags_r, kflags_nxt;
  logic [7:0]          wmask_r, wmask_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic [NW-1:0]       run_r, run_nxt;
  logic [NW-1:0]       need_r, need_nxt;
  logic [NW-1:0]       taken_r, taken_nxt;
  logic [IW-1:0]       start_r, start_nxt;
  logic                pass2_r, pass2_nxt;
  logic [7:0]          rflags_r, rflags_nxt;
  logic [11:0]         qidx_r, qidx_nxt;
  logic                out_valid_r, out_valid_nxt;
  bcpa_pkg::res_t      res_r, res_nxt;

  bcpa_pkg::ram_cmd_t              ram_cmd;
  logic [bcpa_pkg::ENTRY_W-1:0]    ram_rd;

  logic [NW-1:0]  req_need;
  logic [11:0]    req_page;
  logic           rd_alloc;
  logic [7:0]     rd_flags;
  logic           usable;
  logic           accept;

  bcpa_page_ram #(
    .DEPTH (MAX_PAGE_FRAMES)
  ) u_ram (
    .clk     (clk),
    .cmd     (ram_cmd),
    .rd_data (ram_rd)
  );

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Round bytes up to whole pages; drop the page offset of the address.
  assign req_need = NW'((26'(in_req.size_bytes) + 26'(bcpa_pkg::PAGE_BYTES - 1))
                        >> bcpa_pkg::PAGE_SHIFT);
  assign req_page = in_req.address[23:bcpa_pkg::PAGE_SHIFT];
  assign rd_alloc = ram_rd[8];
  assign rd_flags = ram_rd[7:0];
  assign usable   = (in_req.region_type == bcpa_pkg::RT_USABLE_A) ||
                    (in_req.region_type == bcpa_pkg::RT_USABLE_B) ||
                    (in_req.region_type == bcpa_pkg::RT_USABLE_C);

  always_comb begin
    state_nxt     = state_r;
    managed_nxt   = managed_r;
    hint_nxt      = hint_r;
    hint_set_nxt  = hint_set_r;
    kflags_nxt    = kflags_r;
    wmask_nxt     = wmask_r;
    ptr_nxt       = ptr_r;
    run_nxt       = run_r;
    need_nxt      = need_r;
    taken_nxt     = taken_r;
    start_nxt     = start_r;
    pass2_nxt     = pass2_r;
    rflags_nxt    = rflags_r;
    qidx_nxt      = qidx_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    ram_cmd       = '0;
    ram_cmd.addr  = 32'(ptr_r);

    if (cfg_valid) begin
      if (cfg_index == bcpa_pkg::CFG_KERNEL_FLAGS) begin
        kflags_nxt = cfg_data;
      end else begin
        wmask_nxt = cfg_data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          need_nxt   = req_need;
          rflags_nxt = in_req.request_flags;
          run_nxt    = '0;
          taken_nxt  = '0;
          pass2_nxt  = 1'b0;
          qidx_nxt   = in_req.page_index;
          res_nxt    = '0;
          case (in_req.operation)
            bcpa_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (32'(managed_r) >= 32'(MAX_PAGE_FRAMES)) begin
                res_nxt.status = bcpa_pkg::ST_OVERFLOW;
              end else begin
                // Write flags as zero for free pages so unread entries stay clean.
                ram_cmd.wr_en   = 1'b1;
                ram_cmd.addr    = 32'(managed_r);
                ram_cmd.wr_data = usable ? {1'b0, 8'h00} : {1'b1, kflags_r};
                if (usable && !hint_set_r) begin
                  hint_nxt     = IW'(managed_r);
                  hint_set_nxt = 1'b1;
                end
                managed_nxt           = managed_r + 1'b1;
                res_nxt.status        = bcpa_pkg::ST_OK;
                res_nxt.first_page    = 12'(managed_r);
                res_nxt.page_address  = 24'({12'(managed_r), 12'h000});
                res_nxt.granted_bytes = 25'(bcpa_pkg::PAGE_BYTES);
                res_nxt.is_allocated  = !usable;
                res_nxt.page_flags    = usable ? 8'h00 : kflags_r;
              end
            end
            bcpa_pkg::OP_ALLOC: begin
              if (req_need == '0) begin
                res_nxt.status = bcpa_pkg::ST_INVALID;
                out_valid_nxt  = 1'b1;
              end else if (32'(req_need) > 32'(managed_r)) begin
                res_nxt.status = bcpa_pkg::ST_NOMEM;
                out_valid_nxt  = 1'b1;
              end else begin
                ptr_nxt   = CW'(hint_r);
                state_nxt = S_A_RD;
              end
            end
            bcpa_pkg::OP_FREE: begin
              if (req_need == '0 || 32'(req_page) >= 32'(managed_r)) begin
                res_nxt.status = bcpa_pkg::ST_INVALID;
                out_valid_nxt  = 1'b1;
              end else if (32'(req_need) > 32'(managed_r)) begin
                res_nxt.status = bcpa_pkg::ST_NOMEM;
                out_valid_nxt  = 1'b1;
              end else begin
                start_nxt = IW'(req_page);
                ptr_nxt   = CW'(req_page);
                state_nxt = S_F_RD;
              end
            end
            default: begin
              ptr_nxt   = CW'(in_req.page_index);
              state_nxt = S_Q_RD;
            end
          endcase
        end
      end

      // Alloc: first-fit scan from the hint.
      S_A_RD: begin
        if (ptr_r >= managed_r) begin
          res_nxt.status = bcpa_pkg::ST_NOMEM;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_A_EV;
        end
      end
      S_A_EV: begin
        state_nxt = S_A_RD;
        ptr_nxt   = ptr_r + 1'b1;
        if (rd_alloc) begin
          run_nxt = '0;
        end else begin
          run_nxt = run_r + 1'b1;
          if (run_r + 1'b1 == need_r) begin
            start_nxt = IW'(32'(ptr_r) - 32'(need_r) + 32'd1);
            ptr_nxt   = CW'(32'(ptr_r) - 32'(need_r) + 32'd1);
            taken_nxt = '0;
            state_nxt = S_MARK;
          end
        end
      end
      S_MARK: begin
        ram_cmd.wr_en   = 1'b1;
        ram_cmd.wr_data = {1'b1, rflags_r};
        ptr_nxt         = ptr_r + 1'b1;
        taken_nxt       = taken_r + 1'b1;
        if (taken_r + 1'b1 == need_r) begin
          res_nxt.status        = bcpa_pkg::ST_OK;
          res_nxt.first_page    = 12'(start_r);
          res_nxt.page_address  = 24'({12'(start_r), 12'h000});
          res_nxt.granted_bytes = 25'({need_r, 12'h000});
          if (start_r == hint_r) begin
            state_nxt = S_H_RD;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      // Advance the hint to the first free page past the new run.
      S_H_RD: begin
        if (ptr_r >= managed_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_H_EV;
        end
      end
      S_H_EV: begin
        if (!rd_alloc) begin
          hint_nxt      = IW'(ptr_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_H_RD;
        end
      end

      // Free: first walk checks permission, second walk releases.
      S_F_RD: begin
        if (ptr_r >= managed_r || taken_r >= need_r) begin
          if (!pass2_r) begin
            if (taken_r < need_r) begin
              res_nxt.status = bcpa_pkg::ST_NOMEM;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              pass2_nxt = 1'b1;
              taken_nxt = '0;
              ptr_nxt   = CW'(start_r);
            end
          end else begin
            if (hint_r > start_r) begin
              hint_nxt = start_r;
            end
            res_nxt.status        = bcpa_pkg::ST_OK;
            res_nxt.first_page    = 12'(start_r);
            res_nxt.page_address  = 24'({12'(start_r), 12'h000});
            res_nxt.granted_bytes = 25'({need_r, 12'h000});
            out_valid_nxt         = 1'b1;
            state_nxt             = S_IDLE;
          end
        end else begin
          state_nxt = S_F_EV;
        end
      end
      S_F_EV: begin
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_F_RD;
        if (rd_alloc) begin
          taken_nxt = taken_r + 1'b1;
          if (pass2_r) begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_data = {1'b0, rd_flags};
          end else if ((rd_flags & wmask_r) == 8'h00) begin
            res_nxt.status = bcpa_pkg::ST_NOWRITE;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end

      // Query: pages beyond the managed range report invalid status with zero bits.
      S_Q_RD: begin
        res_nxt.first_page   = qidx_r;
        res_nxt.page_address = {qidx_r, 12'h000};
        if (32'(qidx_r) >= 32'(managed_r)) begin
          res_nxt.status = bcpa_pkg::ST_INVALID;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_Q_EV;
        end
      end
      S_Q_EV: begin
        res_nxt.status       = bcpa_pkg::ST_OK;
        res_nxt.is_allocated = rd_alloc;
        res_nxt.page_flags   = rd_flags;
        out_valid_nxt        = 1'b1;
        state_nxt            = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      managed_r   <= '0;
      hint_r      <= '0;
      hint_set_r  <= 1'b0;
      kflags_r    <= 8'd3;
      wmask_r     <= 8'd2;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      managed_r   <= managed_nxt;
      hint_r      <= hint_nxt;
      hint_set_r  <= hint_set_nxt;
      kflags_r    <= kflags_nxt;
      wmask_r     <= wmask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    run_r    <= run_nxt;
    need_r   <= need_nxt;
    taken_r  <= taken_nxt;
    start_r  <= start_nxt;
    pass2_r  <= pass2_nxt;
    rflags_r <= rflags_nxt;
    qidx_r   <= qidx_nxt;
    res_r    <= res_nxt;
  end

endmodule
